/* hw/rtl/bpf_pkg.sv */
package bpf_pkg;

    // coordinate format, signed q16.8
    localparam int COORD_WIDTH     = 24;
    localparam int FRAC_BITS       = 8;
    localparam int MAX_SPLIT_LEVEL = 5;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    // command codes
    typedef enum logic [1:0] {
        OP_MOVE  = 2'd0,
        OP_LINE  = 2'd1,
        OP_CURVE = 2'd2,
        OP_CLOSE = 2'd3
    } t_op;

    // result kinds
    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

endpackage

/* hw/rtl/bezier_path_flattener_top.sv */
// Path flattener: move, line and close each produce one result. A cubic curve
// is split at de Casteljau midpoints, depth first, and every piece of it is
// tested on one shared 33x33 signed multiplier (six products for the control
// distances and the chord, one for the square of the distance sum, then a
// compare-and-split step). Pieces past the split depth run the same steps
// before their end point goes out. At the default split depth of 5 a curve
// visits at most 127 pieces (63 tested and split, 64 at the depth limit).
// The input is stalled while a curve is worked on and while the output
// register holds a result that is not yet taken; a curve also waits at each
// point it emits until the previous result is taken.
module bezier_path_flattener_top
    import bpf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [1:0]   i_operation,
    input  t_coord       i_first_x,
    input  t_coord       i_first_y,
    input  t_coord       i_second_x,
    input  t_coord       i_second_y,
    input  t_coord       i_third_x,
    input  t_coord       i_third_y,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [1:0]   o_kind,
    output t_coord       o_point_x,
    output t_coord       o_point_y,
    output logic         o_is_corner,
    output logic         o_last
);

    localparam int STACK_SLOTS = MAX_SPLIT_LEVEL + 1;
    localparam int STACK_IDX_W = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
    localparam int DEPTH_W     = $clog2(STACK_SLOTS + 1);
    localparam int LVL_W       = $clog2(MAX_SPLIT_LEVEL + 2);
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = 2 * DIFF_W + 2;
    localparam int S_W         = ACC_W;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int CMP_W       = SQ_W + 2 * FRAC_BITS;
    localparam logic [2:0] STEP_LAST = 3'd6;

    typedef enum logic [1:0] {S_IDLE, S_TEST, S_DECIDE} t_state;

    t_state               r_state;
    logic [2:0]           r_step;
    t_coord               r_cur_x, r_cur_y;
    t_coord               r_cx [4];
    t_coord               r_cy [4];
    logic [LVL_W-1:0]     r_level;
    logic [DEPTH_W-1:0]   r_depth;
    t_coord               r_stk_x [STACK_SLOTS][4];
    t_coord               r_stk_y [STACK_SLOTS][4];
    logic [LVL_W-1:0]     r_stk_lvl [STACK_SLOTS];
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [S_W-1:0]       r_s;
    logic                 r_out_valid;
    logic [1:0]           r_kind;
    t_coord               r_px, r_py;
    logic                 r_corner, r_last;

    // floor of the mean of two coordinates
    function automatic t_coord half_sum(input t_coord a, input t_coord b);
        logic signed [COORD_WIDTH:0] s;
        s = $signed({a[COORD_WIDTH-1], a}) + $signed({b[COORD_WIDTH-1], b});
        return s[COORD_WIDTH:1];
    endfunction

    function automatic logic signed [DIFF_W-1:0] diff(input t_coord a, input t_coord b);
        return $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
    endfunction

    // handshake
    logic can_load, accept;
    assign can_load = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == S_IDLE) && can_load);
    assign accept   = i_valid && !o_stall;

    // shared multiplier operand select
    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    assign dx = diff(r_cx[3], r_cx[0]);
    assign dy = diff(r_cy[3], r_cy[0]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            3'd0: begin
                mul_a = MUL_W'(diff(r_cy[1], r_cy[3]));
                mul_b = MUL_W'(dx);
            end
            3'd1: begin
                mul_a = MUL_W'(diff(r_cx[1], r_cx[3]));
                mul_b = MUL_W'(dy);
            end
            3'd2: begin
                mul_a = MUL_W'(diff(r_cy[2], r_cy[3]));
                mul_b = MUL_W'(dx);
            end
            3'd3: begin
                mul_a = MUL_W'(diff(r_cx[2], r_cx[3]));
                mul_b = MUL_W'(dy);
            end
            3'd4: begin
                mul_a = MUL_W'(dx);
                mul_b = MUL_W'(dx);
            end
            3'd5: begin
                mul_a = MUL_W'(dy);
                mul_b = MUL_W'(dy);
            end
            default: begin
                mul_a = $signed({1'b0, r_s[MUL_W-2:0]});
                mul_b = $signed({1'b0, r_s[MUL_W-2:0]});
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // magnitude of the accumulated cross term
    logic [S_W-1:0] acc_mag;
    assign acc_mag = r_acc[ACC_W-1] ? S_W'(-r_acc) : S_W'(r_acc);

    // flatness decision: 4*s*s < (dx*dx + dy*dy) << 2*frac
    logic             s_small, flat, take;
    logic [CMP_W-1:0] lhs, rhs;
    assign s_small = (r_s[S_W-1:MUL_W-1] == '0);
    assign lhs     = CMP_W'({r_prod[PROD_W-3:0], 2'b00});
    assign rhs     = {r_acc[SQ_W-1:0], {(2 * FRAC_BITS){1'b0}}};
    assign flat    = s_small && (lhs < rhs);
    assign take    = (r_level > LVL_W'(MAX_SPLIT_LEVEL)) || flat;

    // midpoint split
    t_coord ax, ay, bx, by, ex, ey, fx, fy, gx, gy, mx, my;
    assign ax = half_sum(r_cx[0], r_cx[1]);
    assign ay = half_sum(r_cy[0], r_cy[1]);
    assign bx = half_sum(r_cx[1], r_cx[2]);
    assign by = half_sum(r_cy[1], r_cy[2]);
    assign ex = half_sum(r_cx[2], r_cx[3]);
    assign ey = half_sum(r_cy[2], r_cy[3]);
    assign fx = half_sum(ax, bx);
    assign fy = half_sum(ay, by);
    assign gx = half_sum(bx, ex);
    assign gy = half_sum(by, ey);
    assign mx = half_sum(fx, gx);
    assign my = half_sum(fy, gy);

    logic [STACK_IDX_W-1:0] push_idx, pop_idx;
    logic                   at_top;
    assign push_idx = r_depth[STACK_IDX_W-1:0];
    assign pop_idx  = STACK_IDX_W'(r_depth - 1'b1);
    assign at_top   = (r_depth == '0);

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_operation))
                        OP_MOVE, OP_LINE: begin
                            r_out_valid <= 1'b1;
                            r_kind      <= (t_op'(i_operation) == OP_MOVE) ?
                                           KIND_MOVE : KIND_POINT;
                            r_px        <= i_first_x;
                            r_py        <= i_first_y;
                            r_corner    <= 1'b1;
                            r_last      <= 1'b1;
                            r_cur_x     <= i_first_x;
                            r_cur_y     <= i_first_y;
                        end
                        OP_CURVE: begin
                            r_cx[0] <= r_cur_x;
                            r_cy[0] <= r_cur_y;
                            r_cx[1] <= i_first_x;
                            r_cy[1] <= i_first_y;
                            r_cx[2] <= i_second_x;
                            r_cy[2] <= i_second_y;
                            r_cx[3] <= i_third_x;
                            r_cy[3] <= i_third_y;
                            r_cur_x <= i_third_x;
                            r_cur_y <= i_third_y;
                            r_level <= '0;
                            r_depth <= '0;
                            r_step  <= '0;
                            r_state <= S_TEST;
                        end
                        default: begin
                            r_out_valid <= 1'b1;
                            r_kind      <= KIND_CLOSE;
                            r_px        <= '0;
                            r_py        <= '0;
                            r_corner    <= 1'b0;
                            r_last      <= 1'b1;
                        end
                    endcase
                end
            end
            S_TEST: begin
                r_prod <= mul_p;
                case (r_step)
                    3'd1: r_acc <= ACC_W'(r_prod);
                    3'd2: r_acc <= r_acc - ACC_W'(r_prod);
                    3'd3: begin
                        r_s   <= acc_mag;
                        r_acc <= ACC_W'(r_prod);
                    end
                    3'd4: r_acc <= r_acc - ACC_W'(r_prod);
                    3'd5: begin
                        r_s   <= r_s + acc_mag;
                        r_acc <= ACC_W'(r_prod);
                    end
                    3'd6: r_acc <= r_acc + ACC_W'(r_prod);
                    default: ;
                endcase
                if (r_step == STEP_LAST) begin
                    r_state <= S_DECIDE;
                end
                r_step <= r_step + 3'd1;
            end
            default: begin
                r_step <= '0;
                if (take) begin
                    if (can_load) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_POINT;
                        r_px        <= r_cx[3];
                        r_py        <= r_cy[3];
                        r_corner    <= at_top;
                        r_last      <= at_top;
                        if (at_top) begin
                            r_state <= S_IDLE;
                        end else begin
                            for (int k = 0; k < 4; k++) begin
                                r_cx[k] <= r_stk_x[pop_idx][k];
                                r_cy[k] <= r_stk_y[pop_idx][k];
                            end
                            r_level <= r_stk_lvl[pop_idx];
                            r_depth <= r_depth - 1'b1;
                            r_state <= S_TEST;
                        end
                    end
                end else begin
                    // right half goes on the stack, left half is tested next
                    r_stk_x[push_idx][0] <= mx;
                    r_stk_y[push_idx][0] <= my;
                    r_stk_x[push_idx][1] <= gx;
                    r_stk_y[push_idx][1] <= gy;
                    r_stk_x[push_idx][2] <= ex;
                    r_stk_y[push_idx][2] <= ey;
                    r_stk_x[push_idx][3] <= r_cx[3];
                    r_stk_y[push_idx][3] <= r_cy[3];
                    r_stk_lvl[push_idx]  <= r_level + 1'b1;
                    r_cx[1] <= ax;
                    r_cy[1] <= ay;
                    r_cx[2] <= fx;
                    r_cy[2] <= fy;
                    r_cx[3] <= mx;
                    r_cy[3] <= my;
                    r_level <= r_level + 1'b1;
                    r_depth <= r_depth + 1'b1;
                    r_state <= S_TEST;
                end
            end
        endcase
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_level     <= '0;
            r_depth     <= '0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kind      = r_kind;
    assign o_point_x   = r_px;
    assign o_point_y   = r_py;
    assign o_is_corner = r_corner;
    assign o_last      = r_last;

endmodule

/* hw/rtl/bpf_checker.sv */
module bpf_checker
    import bpf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_kind,
    input t_coord     o_point_x,
    input t_coord     o_point_y,
    input logic       o_is_corner,
    input logic       o_last
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_x) && $stable(o_point_y)
            && $stable(o_kind) && $stable(o_last))
        else $error("stalled result changed");

    // a result waiting on the receiver blocks the input
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input open while result blocked");

    // close marker carries no point and ends its command
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_CLOSE |->
            o_point_x == '0 && o_point_y == '0 && !o_is_corner && o_last)
        else $error("bad close marker");

    // a corner is always the final point of its command
    a_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_corner |-> o_last)
        else $error("corner not last");

    // a subpath start is a single corner result
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_MOVE |-> o_is_corner && o_last)
        else $error("bad move result");

endmodule

bind bezier_path_flattener_top bpf_checker u_bpf_checker (.*);

/* test/tb_bezier_path_flattener_top.sv */
`timescale 1ns / 1ps

module tb_bezier_path_flattener_top;
    import bpf_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_POINTS     = 64;

    typedef struct {
        logic [1:0] kind;
        t_coord     px;
        t_coord     py;
        logic       corner;
        logic       last;
    } t_point;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_operation;
    t_coord     i_first_x, i_first_y, i_second_x, i_second_y, i_third_x, i_third_y;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_kind;
    t_coord     o_point_x, o_point_y;
    logic       o_is_corner;
    logic       o_last;

    bezier_path_flattener_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_first_x   (i_first_x),
        .i_first_y   (i_first_y),
        .i_second_x  (i_second_x),
        .i_second_y  (i_second_y),
        .i_third_x   (i_third_x),
        .i_third_y   (i_third_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_is_corner (o_is_corner),
        .o_last      (o_last)
    );

    t_point expected_points[$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_tokens = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     quiet_cycles = 0;
    longint pen_x = 0;
    longint pen_y = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // flatness of one piece, exact wide compare
    function automatic bit piece_is_flat(longint c[8]);
        longint dx, dy, a1, a2, s;
        logic signed [127:0] lhs, rhs, s_w, len_w;
        dx = c[6] - c[0];
        dy = c[7] - c[1];
        a1 = (c[3] - c[7]) * dx - (c[2] - c[6]) * dy;
        a2 = (c[5] - c[7]) * dx - (c[4] - c[6]) * dy;
        if (a1 < 0) a1 = -a1;
        if (a2 < 0) a2 = -a2;
        s = a1 + a2;
        if (s >= (64'sd1 <<< 40)) return 1'b0;
        s_w   = s;
        len_w = dx * dx + dy * dy;
        lhs   = (s_w * s_w) <<< 2;
        rhs   = len_w <<< (2 * FRAC_BITS);
        return lhs < rhs;
    endfunction

    function automatic longint mid_of(longint a, longint b);
        return (a + b) >>> 1;
    endfunction

    function automatic void add_point(ref int count, input logic [1:0] kind,
                                      input longint x, input longint y,
                                      input logic corner);
        t_point p;
        if (count >= MAX_POINTS) return;
        p.kind   = kind;
        p.px     = t_coord'(x);
        p.py     = t_coord'(y);
        p.corner = corner;
        p.last   = 1'b0;
        expected_points.push_back(p);
        count++;
    endfunction

    // split a curve depth first, left half first
    function automatic void flatten_points(ref int count, input longint c0[8]);
        longint piece[8];
        longint right_halves[MAX_SPLIT_LEVEL+1][8];
        int     right_levels[MAX_SPLIT_LEVEL+1];
        int     depth, level;
        longint ax, ay, bx, by, ex, ey, fx, fy, gx, gy, mx, my;
        piece = c0;
        depth = 0;
        level = 0;
        forever begin
            if (level > MAX_SPLIT_LEVEL || piece_is_flat(piece)) begin
                add_point(count, KIND_POINT, piece[6], piece[7], depth == 0);
                if (depth == 0) return;
                depth--;
                piece = right_halves[depth];
                level = right_levels[depth];
            end else begin
                ax = mid_of(piece[0], piece[2]); ay = mid_of(piece[1], piece[3]);
                bx = mid_of(piece[2], piece[4]); by = mid_of(piece[3], piece[5]);
                ex = mid_of(piece[4], piece[6]); ey = mid_of(piece[5], piece[7]);
                fx = mid_of(ax, bx); fy = mid_of(ay, by);
                gx = mid_of(bx, ex); gy = mid_of(by, ey);
                mx = mid_of(fx, gx); my = mid_of(fy, gy);
                right_halves[depth] = '{mx, my, gx, gy, ex, ey, piece[6], piece[7]};
                right_levels[depth] = level + 1;
                depth++;
                piece[2] = ax; piece[3] = ay;
                piece[4] = fx; piece[5] = fy;
                piece[6] = mx; piece[7] = my;
                level++;
            end
        end
    endfunction

    // expected points of one accepted command
    function automatic void predict_points(t_op op, t_coord x1, t_coord y1, t_coord x2,
                                           t_coord y2, t_coord x3, t_coord y3);
        int     count;
        longint c[8];
        count = 0;
        case (op)
            OP_MOVE, OP_LINE: begin
                add_point(count, (op == OP_MOVE) ? KIND_MOVE : KIND_POINT,
                          longint'(x1), longint'(y1), 1'b1);
                pen_x = x1;
                pen_y = y1;
            end
            OP_CURVE: begin
                c = '{pen_x, pen_y, longint'(x1), longint'(y1), longint'(x2),
                      longint'(y2), longint'(x3), longint'(y3)};
                pen_x = x3;
                pen_y = y3;
                flatten_points(count, c);
            end
            default: add_point(count, KIND_CLOSE, 0, 0, 1'b0);
        endcase
        if (count > 0) expected_points[$].last = 1'b1;
    endfunction

    // one command transfer
    task automatic send_cmd(t_op op, t_coord x1, t_coord y1, t_coord x2 = '0,
                            t_coord y2 = '0, t_coord x3 = '0, t_coord y3 = '0);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_first_x   <= x1;
        i_first_y   <= y1;
        i_second_x  <= x2;
        i_second_y  <= y2;
        i_third_x   <= x3;
        i_third_y   <= y3;
        do @(posedge i_clk); while (o_stall);
        predict_points(op, x1, y1, x2, y2, x3, y3);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_points.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_coord any_coord();
        return t_coord'($urandom);
    endfunction

    // point near the pen, keeps split depth shallow
    function automatic t_coord near(longint base);
        return t_coord'(base + $signed($urandom_range(4000)) - 2000);
    endfunction

    task automatic send_random_cmd();
        int     pick;
        bit     wide;
        pick = $urandom_range(99);
        wide = ($urandom_range(9) == 0);
        if (pick < 15)
            send_cmd(OP_MOVE, wide ? any_coord() : near(pen_x),
                     wide ? any_coord() : near(pen_y));
        else if (pick < 35)
            send_cmd(OP_LINE, wide ? any_coord() : near(pen_x),
                     wide ? any_coord() : near(pen_y));
        else if (pick < 85) begin
            if (wide)
                send_cmd(OP_CURVE, any_coord(), any_coord(), any_coord(),
                         any_coord(), any_coord(), any_coord());
            else
                send_cmd(OP_CURVE, near(pen_x), near(pen_y), near(pen_x),
                         near(pen_y), near(pen_x), near(pen_y));
        end else
            send_cmd(OP_CLOSE, any_coord(), any_coord(), any_coord(),
                     any_coord(), any_coord(), any_coord());
    endtask

    // extremes, every command, and the special cases
    task automatic test_directed();
        // curve before any move, straight so flat at once
        send_cmd(OP_CURVE, 24'sd256, 24'sd0, 24'sd512, 24'sd0, 24'sd768, 24'sd0);
        send_cmd(OP_LINE, 24'sd1000, -24'sd1000);
        send_cmd(OP_MOVE, 24'sh7fffff, 24'sh7fffff);
        send_cmd(OP_LINE, -24'sh800000, -24'sh800000);
        send_cmd(OP_CLOSE, 24'sh7fffff, -24'sh800000, 24'sh7fffff, -24'sh800000,
                 24'sh7fffff, -24'sh800000);
        send_cmd(OP_MOVE, 24'sd0, 24'sd0);
        // zero chord splits down to the depth limit
        send_cmd(OP_CURVE, 24'sd5000, 24'sd300, -24'sd700, 24'sd9000, 24'sd0, 24'sd0);
        // full range curves
        send_cmd(OP_CURVE, 24'sh7fffff, -24'sh800000, -24'sh800000, 24'sh7fffff,
                 24'sh7fffff, 24'sh7fffff);
        send_cmd(OP_CURVE, -24'sh800000, -24'sh800000, 24'sh7fffff, -24'sh800000,
                 -24'sh800000, -24'sh800000);
        send_cmd(OP_MOVE, -24'sd1, 24'sd1);
        send_cmd(OP_CURVE, 24'sd300, 24'sd800, 24'sd1500, 24'sd900, 24'sd2000, 24'sd0);
        send_cmd(OP_CURVE, 24'sd2010, 24'sd3, 24'sd2020, -24'sd2, 24'sd2030, 24'sd1);
        send_cmd(OP_CLOSE, '0, '0);
        send_cmd(OP_LINE, 24'sd0, 24'sh7fffff);
        go_idle();
    endtask

    task automatic test_random(int sender_pct, int receiver_pct, int count);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (count) send_random_cmd();
        go_idle();
    endtask

    // receiver holds off while commands keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_tokens++;
        repeat (12) begin
            if ($urandom_range(1)) send_cmd(OP_LINE, any_coord(), any_coord());
            else send_cmd(OP_MOVE, any_coord(), any_coord());
        end
        send_cmd(OP_CURVE, near(pen_x), near(pen_y), near(pen_x), near(pen_y),
                 near(pen_x), near(pen_y));
        go_idle();
    endtask

    // sender pauses until every point has come out
    task automatic test_drain_pause();
        wait_drained();
        repeat (20) @(posedge i_clk);
        send_cmd(OP_MOVE, near(0), near(0));
        send_cmd(OP_CURVE, near(pen_x), near(pen_y), near(pen_x), near(pen_y),
                 near(pen_x), near(pen_y));
        go_idle();
    endtask

    // receiver side: random stall plus long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_tokens != hold_seen) begin
                hold_seen = hold_tokens;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // compare each point transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_point p;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                $error("unexpected point transfer kind=%0d x=%0d y=%0d",
                       o_kind, o_point_x, o_point_y);
                fail_count++;
            end else begin
                p = expected_points.pop_front();
                if (o_kind !== p.kind) begin
                    $error("kind: expected %0d actual %0d", p.kind, o_kind);
                    fail_count++;
                end
                if (o_point_x !== p.px) begin
                    $error("point_x: expected %0d actual %0d", p.px, o_point_x);
                    fail_count++;
                end
                if (o_point_y !== p.py) begin
                    $error("point_y: expected %0d actual %0d", p.py, o_point_y);
                    fail_count++;
                end
                if (o_is_corner !== p.corner) begin
                    $error("is_corner: expected %0d actual %0d", p.corner, o_is_corner);
                    fail_count++;
                end
                if (o_last !== p.last) begin
                    $error("last: expected %0d actual %0d", p.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bezier_path_flattener_top regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= OP_MOVE;
        i_first_x   <= '0;
        i_first_y   <= '0;
        i_second_x  <= '0;
        i_second_y  <= '0;
        i_third_x   <= '0;
        i_third_y   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(23, 69, 25);
        test_random(69, 23, 25);
        test_backpressure();
        test_drain_pause();
        test_random(0, 0, 25);

        wait_drained();
        repeat (600) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            $error("%0d expected points never came out", expected_points.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("bezier_path_flattener_top regression: pass");
        end else begin
            $display("bezier_path_flattener_top regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bpf_pkg.sv
hw/rtl/bezier_path_flattener_top.sv
hw/rtl/bpf_checker.sv
test/tb_bezier_path_flattener_top.sv
